// ===== sv/r64e_pkg.sv =====
package r64e_pkg;

  localparam int unsigned CapW      = 12;
  localparam int unsigned CntW      = 13;
  localparam int unsigned CharW     = 7;
  localparam int unsigned NumPairs  = 26;
  localparam int unsigned NumLetter = 2 * NumPairs;

  localparam logic [CapW-1:0] CapReset = 12'd21;

  localparam logic [CharW-1:0] ChLowerA     = 7'h61;
  localparam logic [CharW-1:0] ChUpperA     = 7'h41;
  localparam logic [CharW-1:0] ChDigit0     = 7'h30;
  localparam logic [CharW-1:0] ChUnderscore = 7'h5F;
  localparam logic [CharW-1:0] ChDash       = 7'h2D;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             eom;
    logic             ovf;
  } result_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic [5:0]      leftover;
    logic [CntW-1:0] count;
    logic            discarding;
  } enc_state_t;

  // interleaved alphabet: even index lower case, odd index upper case
  function automatic logic [CharW-1:0] to_char(input logic [5:0] v);
    logic [CharW-1:0] ch;
    if (v < 6'(NumLetter)) begin
      ch = (v[0] ? ChUpperA : ChLowerA) + {2'b00, v[5:1]};
    end else if (v < 6'(NumLetter + 10)) begin
      ch = ChDigit0 + {1'b0, 6'(v - 6'(NumLetter))};
    end else if (v == 6'd62) begin
      ch = ChUnderscore;
    end else begin
      ch = ChDash;
    end
    return ch;
  endfunction

endpackage

// ===== sv/r64e_step.sv =====
module r64e_step (
  input  r64e_pkg::enc_state_t        st_i,
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  input  logic [r64e_pkg::CapW-1:0]   cap_i,
  output r64e_pkg::enc_state_t        st_o,
  output logic [1:0]                  num_o,
  output r64e_pkg::result_t           res0_o,
  output r64e_pkg::result_t           res1_o
);
  import r64e_pkg::*;

  logic [5:0]      v;
  logic [5:0]      lo;
  logic [1:0]      nxt_phase;
  logic [CntW-1:0] cnt1;
  logic [CntW-1:0] cap_ext;
  result_t         ovf_res;

  assign cap_ext = {1'b0, cap_i};
  assign cnt1    = st_i.count + 1'b1;
  assign ovf_res = '{character: '0, eom: 1'b1, ovf: 1'b1};

  always_comb begin
    case (st_i.phase)
      2'd1: begin
        v         = {st_i.leftover[1:0], byte_i[7:4]};
        lo        = {2'b00, byte_i[3:0]};
        nxt_phase = 2'd2;
      end
      2'd2: begin
        v         = {st_i.leftover[3:0], byte_i[7:6]};
        lo        = byte_i[5:0];
        nxt_phase = 2'd0;
      end
      default: begin
        v         = byte_i[7:2];
        lo        = {4'b0000, byte_i[1:0]};
        nxt_phase = 2'd1;
      end
    endcase
  end

  always_comb begin
    st_o   = st_i;
    num_o  = 2'd0;
    res0_o = ovf_res;
    res1_o = ovf_res;
    if (st_i.discarding) begin
      if (last_i) begin
        st_o = '0;
      end
    end else if (st_i.count >= cap_ext) begin
      num_o = 2'd1;
      if (last_i) begin
        st_o = '0;
      end else begin
        st_o.discarding = 1'b1;
      end
    end else if (nxt_phase == 2'd0) begin
      // third byte of a group gives two characters
      num_o  = 2'd2;
      res0_o = '{character: to_char(v), eom: 1'b0, ovf: 1'b0};
      if (cnt1 >= cap_ext) begin
        if (last_i) begin
          st_o = '0;
        end else begin
          st_o.phase      = nxt_phase;
          st_o.leftover   = lo;
          st_o.count      = cnt1;
          st_o.discarding = 1'b1;
        end
      end else begin
        res1_o = '{character: to_char(lo), eom: last_i, ovf: 1'b0};
        if (last_i) begin
          st_o = '0;
        end else begin
          st_o.phase    = nxt_phase;
          st_o.leftover = '0;
          st_o.count    = cnt1 + 1'b1;
        end
      end
    end else begin
      num_o  = 2'd1;
      res0_o = '{character: to_char(v), eom: last_i, ovf: 1'b0};
      if (last_i) begin
        st_o = '0;
      end else begin
        st_o.phase    = nxt_phase;
        st_o.leftover = lo;
        st_o.count    = cnt1;
      end
    end
  end

endmodule

// ===== sv/r64e_outq.sv =====
module r64e_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_num_i,
  input  r64e_pkg::result_t push0_i,
  input  r64e_pkg::result_t push1_i,
  output logic [1:0]        free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output r64e_pkg::result_t head_o
);
  import r64e_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    e0_q, e0_d;
  result_t    e1_q, e1_d;
  logic       pop;
  logic [1:0] a_cnt;
  result_t    a0;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign a_cnt   = cnt_q - {1'b0, pop};
  assign a0      = pop ? e1_q : e0_q;
  assign free_o  = 2'd2 - a_cnt;
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = e0_q;

  always_comb begin
    e0_d  = a0;
    e1_d  = e1_q;
    cnt_d = a_cnt + push_num_i;
    case (a_cnt)
      2'd0: begin
        e0_d = push0_i;
        e1_d = push1_i;
      end
      2'd1: begin
        e1_d = push0_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// ===== sv/radix64_text_encoder.sv =====
// radix64_text_encoder
// Byte stream in on the s_axis channel (tdata = one message byte, tlast marks
// the final byte of a message); printable characters out on m_axis (tdata[6:0]
// = character, tlast = end of message, tuser = overflow). Each 6-bit group
// becomes one character of an interleaved alphabet (a A b B ... 0-9 _ -);
// leftover bits of a partial final group are dropped without padding.
// The one setting, out_capacity, is written through cfg_we_i/cfg_wdata_i; the
// user must write it only while the block is idle (the block does not enforce
// this). When a message reaches capacity one overflow result (character 0,
// tlast 1, tuser 1) is sent and the rest of the message dropped. A byte taken
// from s_axis is held in the input register; its characters then go through
// the result queue that drives m_axis. A byte is taken every cycle as long as
// the two-entry result queue has room; every third byte gives two characters,
// so the output port sets the sustained rate. When m_axis stalls, results wait
// in the queue and then the input register holds its byte and s_axis_tready
// drops. Reset clears the queue, the input register and the group state and
// sets out_capacity to 21.
module radix64_text_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,      // out_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,     // data_byte
  input  logic        s_axis_tlast,     // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,     // character[6:0], zero pad
  output logic        m_axis_tlast,     // end_of_message
  output logic        m_axis_tuser      // overflow
);
  import r64e_pkg::*;

  logic [CapW-1:0] cap_q;
  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  enc_state_t      st_q, st_d;
  logic [1:0]      num;
  result_t         res0, res1;
  logic [1:0]      free;
  logic            fire;
  logic            take;
  result_t         head;

  r64e_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cap_i  (cap_q),
    .st_o   (st_d),
    .num_o  (num),
    .res0_o (res0),
    .res1_o (res1)
  );

  // an item moves on only when all its results fit in the queue
  assign fire = in_valid_q && (num <= free);
  assign take = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || fire;
  assign in_valid_d = take || (in_valid_q && !fire);

  r64e_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (fire ? num : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .free_o     (free),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = {1'b0, head.character};
  assign m_axis_tlast = head.eom;
  assign m_axis_tuser = head.ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapReset;
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      in_valid_q <= in_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

endmodule

// ===== dv/radix64_text_encoder_checker.sv =====
module radix64_text_encoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import r64e_pkg::*;

  logic [CapW-1:0] capacity;
  logic [1:0]      group_pos;
  logic [5:0]      carry_bits;
  logic [CntW-1:0] chars_sent;
  logic            dropping;
  result_t         chars_due[$];

  function automatic logic [CharW-1:0] char_for(input logic [5:0] idx);
    logic [CharW-1:0] ch;
    if (idx < 6'd52) begin
      ch = (idx[0] ? ChUpperA : ChLowerA) + CharW'(idx >> 1);
    end else if (idx < 6'd62) begin
      ch = ChDigit0 + CharW'(idx - 6'd52);
    end else if (idx == 6'd62) begin
      ch = ChUnderscore;
    end else begin
      ch = ChDash;
    end
    return ch;
  endfunction

  task automatic push_char(input logic [CharW-1:0] ch, input logic eom, input logic ovf);
    result_t r;
    r.character = ch;
    r.eom       = eom;
    r.ovf       = ovf;
    chars_due.push_back(r);
  endtask

  task automatic clear_message();
    group_pos  = 2'd0;
    carry_bits = 6'd0;
    chars_sent = '0;
  endtask

  // overflow marker, then either the message ends here or the rest is dropped
  task automatic overflow_out(input logic last);
    push_char('0, 1'b1, 1'b1);
    if (last) begin
      clear_message();
    end else begin
      dropping = 1'b1;
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [5:0] idx;
    logic       cut;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        clear_message();
      end
    end else if (chars_sent >= capacity) begin
      overflow_out(last);
    end else begin
      case (group_pos)
        2'd1: begin
          idx        = {carry_bits[1:0], b[7:4]};
          carry_bits = {2'b00, b[3:0]};
          group_pos  = 2'd2;
        end
        2'd2: begin
          idx        = {carry_bits[3:0], b[7:6]};
          carry_bits = b[5:0];
          group_pos  = 2'd0;
        end
        default: begin
          idx        = b[7:2];
          carry_bits = {4'b0000, b[1:0]};
          group_pos  = 2'd1;
        end
      endcase
      chars_sent = chars_sent + 1'b1;
      cut = 1'b0;
      // third byte of a group gives a second character from the low six bits
      if (group_pos == 2'd0) begin
        push_char(char_for(idx), 1'b0, 1'b0);
        if (chars_sent >= capacity) begin
          overflow_out(last);
          cut = 1'b1;
        end else begin
          idx        = carry_bits;
          carry_bits = 6'd0;
          chars_sent = chars_sent + 1'b1;
        end
      end
      if (!cut) begin
        push_char(char_for(idx), last, 1'b0);
        if (last) begin
          clear_message();
        end
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (chars_due.size() == 0) begin
      fail_count_o++;
      $display("%0t: m_axis transfer with none expected, expected none,",
               $time,
               " actual tdata %h tlast %b tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end else begin
      want = chars_due.pop_front();
      if (m_axis_tdata !== {1'b0, want.character} || m_axis_tlast !== want.eom ||
          m_axis_tuser !== want.ovf) begin
        fail_count_o++;
        $display("%0t: m_axis mismatch, expected tdata %h tlast %b tuser %b,",
                 $time, {1'b0, want.character}, want.eom, want.ovf,
                 " actual tdata %h tlast %b tuser %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity     = CapReset;
      dropping     = 1'b0;
      clear_message();
      chars_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      pending_o = chars_due.size();
    end
  end

endmodule

// ===== dv/radix64_text_encoder_test.sv =====
module radix64_text_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  int unsigned fail_count;
  int unsigned chars_due;
  logic        back_to_back;

  radix64_text_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  radix64_text_encoder_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (chars_due)
  );

  always begin
    clk_i <= 1'b0;
    #4;
    clk_i <= 1'b1;
    #4;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 60) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 12);
    end else if (r < 90) begin
      return $urandom_range(13, 40);
    end
    return $urandom_range(41, 120);
  endfunction

  function automatic logic [11:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 12'($urandom_range(0, 3));
    end else if (r < 60) begin
      return 12'($urandom_range(4, 40));
    end else if (r < 85) begin
      return 12'($urandom_range(41, 4094));
    end
    return 12'd4095;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // bytes that produce nothing may still sit inside the block, so keep waiting after the queue empties
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (chars_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [11:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned stop_at;
    int unsigned phase_items;
    int unsigned len;
    int unsigned total;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    back_to_back  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: full groups over the alphabet ends, then a lone partial group
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b1);
    send_byte(8'hF8, 1'b1);
    // capacity hit between the two characters of a third byte, then dropped bytes
    drain();
    write_capacity(12'd3);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    // capacity already reached when the last byte arrives
    drain();
    write_capacity(12'd2);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hCC, 1'b1);
    // zero capacity overflows on the first byte
    drain();
    write_capacity(12'd0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    // capacity lowered in the middle of a message
    drain();
    write_capacity(12'd4095);
    send_byte(8'h9C, 1'b0);
    send_byte(8'hE7, 1'b0);
    drain();
    write_capacity(12'd1);
    send_byte(8'h3C, 1'b1);

    total = 0;
    while (total < 1400) begin
      drain();
      write_capacity(pick_capacity());
      back_to_back = ($urandom_range(0, 3) == 0);
      phase_items  = $urandom_range(60, 200);
      stop_at      = total + phase_items;
      while (total < stop_at) begin
        len = pick_length();
        send_random_message(len);
        total += len;
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && chars_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: bursts with no back-pressure mix at random with bursts of random stalls
  initial begin
    int unsigned burst_left;
    int unsigned stall_left;
    int unsigned r;
    logic        steady;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    stall_left    = 0;
    steady        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 200);
        steady     = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_axis_tready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(9, 39);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
